### rtl/core/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared constants and types for the flood duplicate filter.
// ----------------------------------------------------------------------------
package fdf_pkg;

    localparam int TABLE_DEPTH = 50;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 16;
    localparam int HOP_W       = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_AGE   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_NEW     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SEEN    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FORWARD = 2'd2;

    typedef struct packed {
        logic             wr_en;
        logic             clr_en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic [HOP_W-1:0] hop;
    } tbl_wr_t;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
        logic [IDX_W-1:0] res;
        if (slot == IDX_W'(TABLE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

endpackage

### rtl/core/fdf_store.sv
// ----------------------------------------------------------------------------
// fdf_store
// Entry table: key/hop memory with registered read and per-entry valid bits.
// Entries that are not valid read as key 0, hop 0.
// ----------------------------------------------------------------------------
module fdf_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [fdf_pkg::IDX_W-1:0] rd_addr,
    output logic [fdf_pkg::KEY_W-1:0] rd_key,
    output logic [fdf_pkg::HOP_W-1:0] rd_hop,
    input  fdf_pkg::tbl_wr_t          wr
);
    import fdf_pkg::*;

    logic [KEY_W+HOP_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W+HOP_W-1:0] rd_data_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr.addr] <= {wr.key, wr.hop};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.wr_en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            else if (wr.clr_en)
            begin
                valid_reg[wr.addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_key = rd_valid_reg ? rd_data_reg[KEY_W+HOP_W-1:HOP_W] : '0;
    assign rd_hop = rd_valid_reg ? rd_data_reg[HOP_W-1:0] : '0;

endmodule

### rtl/core/flood_duplicate_filter_unit.sv
// ----------------------------------------------------------------------------
// flood_duplicate_filter_unit
// Duplicate packet cache: query, add/update and age commands over a table.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Query and add scan the
// table one entry per cycle through the single memory read port, stopping at
// the first match or after the last entry, with busy high during the scan.
// Age and the unused command do not scan; done follows in the cycle after the
// accept. The result is shown with done for one cycle only; the receiver
// cannot stall it. A new word may be started in the same cycle that done is
// high.
module flood_duplicate_filter_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fdf_pkg::CMD_W-1:0]    command,
    input  logic [fdf_pkg::KEY_W-1:0]    packet_key,
    input  logic [fdf_pkg::HOP_W-1:0]    hop_count,
    output logic                         done,
    output logic [fdf_pkg::STATUS_W-1:0] seen_status
);
    import fdf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HOP_W-1:0]    hop_reg, hop_next;
    logic [IDX_W:0]      addr_reg, addr_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic             accept;
    logic             match;
    logic             last;
    logic             finish;
    logic             lower;
    logic             rd_en;
    logic [KEY_W-1:0] rd_key;
    logic [HOP_W-1:0] rd_hop;
    tbl_wr_t          wr;

    fdf_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_key  (rd_key),
        .rd_hop  (rd_hop),
        .wr      (wr)
    );

    always_comb
    begin
        accept = start && (state_reg == ST_IDLE);
        match  = pend_reg && (rd_key == key_reg);
        last   = pend_reg && (pidx_reg == IDX_W'(TABLE_DEPTH - 1));
        finish = (state_reg == ST_SCAN) && (match || last);
        lower  = rd_hop < hop_reg;
        rd_en  = (state_reg == ST_SCAN) && !finish
                 && (addr_reg != (IDX_W + 1)'(TABLE_DEPTH));

        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        hop_next    = hop_reg;
        addr_next   = addr_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        cursor_next = cursor_reg;
        done_next   = 1'b0;
        status_next = status_reg;

        wr        = '0;
        wr.addr   = cursor_reg;
        wr.key    = key_reg;
        wr.hop    = hop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    key_next = packet_key;
                    hop_next = hop_count;
                    if (command == CMD_QUERY || command == CMD_ADD)
                    begin
                        state_next = ST_SCAN;
                        addr_next  = '0;
                        pend_next  = 1'b0;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_NEW;
                        if (command == CMD_AGE)
                        begin
                            wr.clr_en   = 1'b1;
                            cursor_next = next_slot(cursor_reg);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                    pend_next  = 1'b0;
                    done_next  = 1'b1;
                    if (match)
                    begin
                        status_next = lower ? STATUS_FORWARD : STATUS_SEEN;
                    end
                    else
                    begin
                        status_next = STATUS_NEW;
                    end
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (match)
                        begin
                            wr.wr_en = lower;
                            wr.addr  = pidx_reg;
                        end
                        else
                        begin
                            wr.wr_en    = 1'b1;
                            cursor_next = next_slot(cursor_reg);
                        end
                    end
                end
                else
                begin
                    pend_next = rd_en;
                    pidx_next = addr_reg[IDX_W-1:0];
                    if (rd_en)
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            addr_reg   <= '0;
            pend_reg   <= 1'b0;
            pidx_reg   <= '0;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_NEW;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            pend_reg   <= pend_next;
            pidx_reg   <= pidx_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        hop_reg <= hop_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign seen_status = status_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= IDX_W'(TABLE_DEPTH - 1))
        else $error("cursor out of range");

    a_age_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_AGE) |=> (done && seen_status == STATUS_NEW))
        else $error("age result missing");

    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_QUERY || command == CMD_ADD)) |=> (busy && !done))
        else $error("scan not started");

    a_cursor_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg != $past(cursor_reg)) |-> ($past(wr.clr_en) || $past(wr.wr_en)))
        else $error("cursor moved without a table write");

endmodule

### dv/tb_flood_duplicate_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_flood_duplicate_filter_unit
// Self-checking bench for the duplicate packet cache. A software copy of the
// table tracks every accepted word and predicts its status. Directed words hit
// the empty table, updates, key zero, aging and the spare command. Random
// traffic then runs mostly over a small key pool with random sender gaps,
// and ends with a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_flood_duplicate_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fdf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int KEY_POOL_SIZE  = 24;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_W-1:0]    key;
        logic [HOP_W-1:0]    hop;
        logic [STATUS_W-1:0] status;
    } lookup_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    command;
    logic [KEY_W-1:0]    packet_key;
    logic [HOP_W-1:0]    hop_count;
    logic                done;
    logic [STATUS_W-1:0] seen_status;

    logic [KEY_W-1:0] key_tbl [TABLE_DEPTH];
    logic [HOP_W-1:0] hop_tbl [TABLE_DEPTH];
    int               cursor;

    lookup_t          status_due_q [$];
    lookup_t          mon_word;
    lookup_t          mon_due;
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    bit idle_en;
    int fail_cnt;
    int quiet_cycles;
    int cmd_cnt [4];
    int status_cnt [4];

    flood_duplicate_filter_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .packet_key  (packet_key),
        .hop_count   (hop_count),
        .done        (done),
        .seen_status (seen_status)
    );

    always #5ns clk = ~clk;

    function automatic void advance_cursor();
        cursor = (cursor == TABLE_DEPTH - 1) ? 0 : cursor + 1;
    endfunction

    // Applies one word to the table copy; returns the status it yields.
    function automatic logic [STATUS_W-1:0] filter_apply(input logic [CMD_W-1:0] cmd,
                                                         input logic [KEY_W-1:0] key,
                                                         input logic [HOP_W-1:0] hop);
        int                  hit;
        logic [STATUS_W-1:0] st;
        hit = -1;
        st  = STATUS_NEW;
        if (cmd == CMD_QUERY || cmd == CMD_ADD)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (hit < 0 && key_tbl[i] == key)
                begin
                    hit = i;
                end
            end
            if (hit >= 0)
            begin
                st = (hop_tbl[hit] < hop) ? STATUS_FORWARD : STATUS_SEEN;
            end
            if (cmd == CMD_ADD)
            begin
                if (hit >= 0)
                begin
                    if (hop_tbl[hit] < hop)
                    begin
                        hop_tbl[hit] = hop;
                    end
                end
                else
                begin
                    key_tbl[cursor] = key;
                    hop_tbl[cursor] = hop;
                    advance_cursor();
                end
            end
        end
        else if (cmd == CMD_AGE)
        begin
            key_tbl[cursor] = '0;
            hop_tbl[cursor] = '0;
            advance_cursor();
        end
        return st;
    endfunction

    task automatic report_mismatch(input string what);
        fail_cnt++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Sends one word; returns after the edge that accepts it, once busy is low.
    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic [KEY_W-1:0] key,
                             input logic [HOP_W-1:0] hop);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            start      <= 1'b0;
            command    <= CMD_W'($urandom);
            packet_key <= KEY_W'($urandom);
            hop_count  <= HOP_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        packet_key <= key;
        hop_count  <= hop;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Predict on accept first, so a same-edge done still finds its entry.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            mon_word.cmd    = command;
            mon_word.key    = packet_key;
            mon_word.hop    = hop_count;
            mon_word.status = filter_apply(command, packet_key, hop_count);
            status_due_q.push_back(mon_word);
            cmd_cnt[command]++;
        end
        if (rst_n && done)
        begin
            status_cnt[seen_status]++;
            if (status_due_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no word pending", seen_status));
            end
            else
            begin
                mon_due = status_due_q.pop_front();
                if (seen_status !== mon_due.status)
                begin
                    report_mismatch($sformatf("cmd %0d key %h hop %0d: status %0d, want %0d",
                                              mon_due.cmd, mon_due.key, mon_due.hop,
                                              seen_status, mon_due.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no activity, %0d words pending", $time,
                     status_due_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_word(CMD_QUERY, 16'h0000, 8'h00);
        send_word(CMD_QUERY, 16'h0000, 8'h01);
        send_word(CMD_QUERY, 16'hFFFF, 8'hFF);
        send_word(CMD_QUERY, 16'h0001, 8'h00);
    endtask

    task automatic test_add_update();
        send_word(CMD_ADD,   16'hFFFF, 8'hFF);
        send_word(CMD_ADD,   16'hFFFF, 8'h00);
        send_word(CMD_QUERY, 16'hFFFF, 8'hFF);
        send_word(CMD_ADD,   16'h5A5A, 8'h10);
        send_word(CMD_ADD,   16'h5A5A, 8'h80);
        send_word(CMD_QUERY, 16'h5A5A, 8'h7F);
        send_word(CMD_ADD,   16'hA5A5, 8'h01);
    endtask

    // Empty slots hold key zero, so key zero hits the first of them.
    task automatic test_key_zero();
        send_word(CMD_ADD,   16'h0000, 8'h40);
        send_word(CMD_QUERY, 16'h0000, 8'h40);
        send_word(CMD_QUERY, 16'h0000, 8'h41);
    endtask

    task automatic test_age_and_spare();
        send_word(CMD_AGE,   16'hFFFF, 8'hFF);
        send_word(CMD_QUERY, 16'h0000, 8'h01);
        send_word(CMD_SPARE, 16'h5A5A, 8'hFF);
        send_word(CMD_QUERY, 16'h5A5A, 8'hFF);
        send_word(CMD_AGE,   16'h0000, 8'h00);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end
        else if (r < 92)
        begin
            return KEY_W'($urandom);
        end
        return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    endfunction

    function automatic logic [HOP_W-1:0] pick_hop();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return HOP_W'($urandom_range(0, 3));
        end
        else if (r == 1)
        begin
            return HOP_W'($urandom_range(252, 255));
        end
        return HOP_W'($urandom);
    endfunction

    task automatic test_random_traffic(input int n_words, input bit with_idle);
        int               r;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
        begin
            key_pool[i] = KEY_W'($urandom);
        end
        for (int i = 0; i < n_words; i++)
        begin
            if (i % 100 == 0)
            begin
                idle_en = with_idle && ($urandom_range(0, 2) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                cmd = CMD_QUERY;
            end
            else if (r < 80)
            begin
                cmd = CMD_ADD;
            end
            else if (r < 95)
            begin
                cmd = CMD_AGE;
            end
            else
            begin
                cmd = CMD_SPARE;
            end
            send_word(cmd, pick_key(), pick_hop());
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        command    <= CMD_QUERY;
        packet_key <= '0;
        hop_count  <= '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            key_tbl[i] = '0;
            hop_tbl[i] = '0;
        end
        cursor  = 0;
        idle_en = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_add_update();
        test_key_zero();
        test_age_and_spare();
        test_random_traffic(1700, 1'b1);
        test_random_traffic(300, 1'b0);

        start <= 1'b0;
        while (status_due_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Words: %0d query, %0d add, %0d age, %0d spare command",
                 cmd_cnt[CMD_QUERY], cmd_cnt[CMD_ADD], cmd_cnt[CMD_AGE], cmd_cnt[CMD_SPARE]);
        $display("Results: %0d new, %0d seen, %0d forward; %0d mismatches",
                 status_cnt[STATUS_NEW], status_cnt[STATUS_SEEN],
                 status_cnt[STATUS_FORWARD], fail_cnt);
        if (fail_cnt == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/fdf_pkg.sv
rtl/core/fdf_store.sv
rtl/core/flood_duplicate_filter_unit.sv
dv/tb_flood_duplicate_filter_unit.sv
